FILE: rtl/core/rtcalarm_pkg.sv
// Constants and encode/decode helpers for the alarm time calculation unit.
package rtcalarm_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_BCD = 2'd0;
  localparam logic [1:0] CFG_IDX_H12 = 2'd1;

  // Time constants.
  localparam logic [16:0] MAX_DELAY    = 17'd86399;
  localparam logic [16:0] DAY_SECONDS  = 17'd86400;
  localparam logic [11:0] HOUR_SECONDS = 12'd3600;
  localparam logic [5:0]  MIN_SECONDS  = 6'd60;
  localparam logic [4:0]  NOON_HOUR    = 5'd12;

  // Hour byte fields in twelve-hour form.
  localparam logic [7:0]  PM_BIT    = 8'h80;
  localparam logic [6:0]  HOUR_MASK = 7'h7F;

  // Reciprocal multipliers for the constant divisions.
  // Day: (x >> 7) / 675, hour: (x >> 4) / 225, minute: (x >> 2) / 15.
  localparam logic [6:0]  RECIP_DAY  = 7'd97;
  localparam logic [8:0]  RECIP_HOUR = 9'd291;
  localparam logic [10:0] RECIP_MIN  = 11'd1092;

  // Decodes a time byte: low nibble plus ten times high nibble when BCD.
  function automatic logic [7:0] dec_byte(input logic [7:0] b, input logic bcd);
    logic [7:0] tens;
    tens = 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0});
    if (bcd) begin
      return 8'(b[3:0]) + tens;
    end
    return b;
  endfunction

  // Encodes a value below 64 as a time byte.
  function automatic logic [7:0] enc_byte(input logic [5:0] v, input logic bcd);
    logic [3:0] tens;
    logic [5:0] ones;
    if (v >= 6'd60) begin
      tens = 4'd6;
    end else if (v >= 6'd50) begin
      tens = 4'd5;
    end else if (v >= 6'd40) begin
      tens = 4'd4;
    end else if (v >= 6'd30) begin
      tens = 4'd3;
    end else if (v >= 6'd20) begin
      tens = 4'd2;
    end else if (v >= 6'd10) begin
      tens = 4'd1;
    end else begin
      tens = 4'd0;
    end
    ones = v - 6'({tens, 3'b000}) - 6'({tens, 1'b0});
    if (bcd) begin
      return {tens, ones[3:0]};
    end
    return 8'(v);
  endfunction

endpackage

FILE: rtl/core/rtc_alarm_time_compute_unit.sv
// Alarm time calculation unit: current clock time plus a delay, in clock byte format.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------
//  input   | start / busy         | in_now_second, in_now_minute, in_now_hour,
//          |                      | in_delay_seconds
//  result  | out_valid (strobe)   | out_alarm_valid, out_alarm_second,
//          |                      | out_alarm_minute, out_alarm_hour
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// A request is taken on every cycle in which start is high and busy is low, so one
// request can enter per clock. Its result passes through the five register ranks
// (input, seconds sum, day reduction, hour split, result) and is taken on the
// out_valid strobe. busy is high only during reset and on the cycle right after it.
// The receiver cannot stall the pipeline, and configuration writes are always
// ready. Reset sets BCD encoding and 24-hour mode.
module rtc_alarm_time_compute_unit
  import rtcalarm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_now_second,
  input  logic [7:0]  in_now_minute,
  input  logic [7:0]  in_now_hour,
  input  logic [16:0] in_delay_seconds,
  output logic        out_valid,
  output logic        out_alarm_valid,
  output logic [7:0]  out_alarm_second,
  output logic [7:0]  out_alarm_minute,
  output logic [7:0]  out_alarm_hour,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_wdata
);

  // Configuration registers.
  logic bcd_r;
  logic h12_r;

  // Control: busy flag and one valid bit per pipeline rank.
  logic busy_r;
  logic v0_r, v1_r, v2_r, v3_r;
  logic out_valid_r;
  logic accept;

  // The zero-delay flag travels with each request.
  logic nz0_r, nz1_r, nz2_r, nz3_r;

  // Rank 0: decoded time fields and saturated delay.
  logic [7:0]  sec0_r, min0_r, hr0_r;
  logic [16:0] dly0_r;
  logic [7:0]  hr0_nxt;
  logic [16:0] dly0_nxt;
  logic [7:0]  hr_dec;
  logic        pm_in;

  // Rank 1: absolute seconds count, before the modulo-day reduction.
  logic [19:0] sum_r, sum_nxt;

  // Rank 2: seconds into the day.
  logic [19:0] day_prod;
  logic [3:0]  day_q;
  logic [19:0] day_rem;
  logic [16:0] alarm_r, alarm_nxt;

  // Rank 3: hour of the day and seconds into that hour.
  logic [20:0] hr_prod;
  logic [4:0]  hr_est;
  logic [16:0] hr_rem;
  logic [4:0]  hour_r, hour_nxt;
  logic [11:0] rem_r, rem_nxt;

  // Rank 4: minute and second split and encoding.
  logic [19:0] min_prod;
  logic [5:0]  min_est;
  logic [11:0] sec_rem;
  logic [5:0]  min_val;
  logic [5:0]  sec_val;
  logic        pm_out;
  logic [4:0]  h12_val;
  logic [7:0]  hour_enc;

  logic       out_alarm_valid_r;
  logic [7:0] out_alarm_second_r, out_alarm_minute_r, out_alarm_hour_r;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Configuration writes; an index outside the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcd_r <= 1'b1;
      h12_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_BCD: bcd_r <= cfg_wdata;
        CFG_IDX_H12: h12_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hour decode. In twelve-hour mode bit 7 is the PM flag: PM adds twelve to an
  // hour below noon, and twelve o'clock AM is midnight. Other values pass as they are.
  always_comb begin
    pm_in   = in_now_hour[7];
    hr_dec  = dec_byte({1'b0, in_now_hour[6:0] & HOUR_MASK}, bcd_r);
    hr0_nxt = dec_byte(in_now_hour, bcd_r);
    if (h12_r) begin
      hr0_nxt = hr_dec;
      if (pm_in && (hr_dec < 8'(NOON_HOUR))) begin
        hr0_nxt = hr_dec + 8'(NOON_HOUR);
      end else if (!pm_in && (hr_dec == 8'(NOON_HOUR))) begin
        hr0_nxt = 8'd0;
      end
    end
    dly0_nxt = (in_delay_seconds > MAX_DELAY) ? MAX_DELAY : in_delay_seconds;
  end

  // The weighted sum fits in 20 bits even for out-of-range fields.
  assign sum_nxt = 20'(hr0_r) * 20'(HOUR_SECONDS) + 20'(min0_r) * 20'(MIN_SECONDS)
                 + 20'(sec0_r) + 20'(dly0_r);

  // Modulo one day. The quotient estimate is exact or one short, so a single
  // conditional subtract finishes the reduction.
  always_comb begin
    day_prod  = 20'(sum_r[19:7]) * 20'(RECIP_DAY);
    day_q     = day_prod[19:16];
    day_rem   = sum_r - 20'(day_q) * 20'(DAY_SECONDS);
    alarm_nxt = (day_rem >= 20'(DAY_SECONDS)) ? 17'(day_rem - 20'(DAY_SECONDS))
                                              : day_rem[16:0];
  end

  // Hour split with the same estimate-and-correct scheme.
  always_comb begin
    hr_prod  = 21'(alarm_r[16:4]) * 21'(RECIP_HOUR);
    hr_est   = hr_prod[20:16];
    hr_rem   = alarm_r - 17'(hr_est) * 17'(HOUR_SECONDS);
    hour_nxt = hr_est;
    rem_nxt  = hr_rem[11:0];
    if (hr_rem >= 17'(HOUR_SECONDS)) begin
      hour_nxt = hr_est + 5'd1;
      rem_nxt  = 12'(hr_rem - 17'(HOUR_SECONDS));
    end
  end

  // Minute and second split, then encoding of all three bytes.
  always_comb begin
    min_prod = 20'(rem_r[11:2]) * 20'(RECIP_MIN);
    min_est  = min_prod[19:14];
    sec_rem  = rem_r - 12'(min_est) * 12'(MIN_SECONDS);
    min_val  = min_est;
    sec_val  = sec_rem[5:0];
    if (sec_rem >= 12'(MIN_SECONDS)) begin
      min_val = min_est + 6'd1;
      sec_val = 6'(sec_rem - 12'(MIN_SECONDS));
    end
    // Twelve-hour encode: midnight and noon both read as twelve.
    pm_out  = hour_r >= NOON_HOUR;
    h12_val = pm_out ? (hour_r - NOON_HOUR) : hour_r;
    if (h12_val == 5'd0) begin
      h12_val = NOON_HOUR;
    end
    if (h12_r) begin
      hour_enc = enc_byte(6'(h12_val), bcd_r) | (pm_out ? PM_BIT : 8'h00);
    end else begin
      hour_enc = enc_byte(6'(hour_r), bcd_r);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      v0_r        <= accept;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Datapath registers; they load every cycle and the valid bits say which ranks count.
  always_ff @(posedge clk) begin
    sec0_r  <= dec_byte(in_now_second, bcd_r);
    min0_r  <= dec_byte(in_now_minute, bcd_r);
    hr0_r   <= hr0_nxt;
    dly0_r  <= dly0_nxt;
    nz0_r   <= in_delay_seconds != 17'd0;
    sum_r   <= sum_nxt;
    nz1_r   <= nz0_r;
    alarm_r <= alarm_nxt;
    nz2_r   <= nz1_r;
    hour_r  <= hour_nxt;
    rem_r   <= rem_nxt;
    nz3_r   <= nz2_r;
    // A zero delay gives a result with no alarm and all time bytes cleared.
    out_alarm_valid_r  <= nz3_r;
    out_alarm_second_r <= nz3_r ? enc_byte(sec_val, bcd_r) : 8'h00;
    out_alarm_minute_r <= nz3_r ? enc_byte(min_val, bcd_r) : 8'h00;
    out_alarm_hour_r   <= nz3_r ? hour_enc : 8'h00;
  end

  assign out_valid        = out_valid_r;
  assign out_alarm_valid  = out_alarm_valid_r;
  assign out_alarm_second = out_alarm_second_r;
  assign out_alarm_minute = out_alarm_minute_r;
  assign out_alarm_hour   = out_alarm_hour_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted request produced no result five edges later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without a matching request");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> alarm_r < DAY_SECONDS)
    else $error("day reduction out of range");

  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (hour_r < 5'd24) && (rem_r < HOUR_SECONDS))
    else $error("hour split out of range");

  a_zero_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_alarm_valid) |->
      (out_alarm_second == 8'h00) && (out_alarm_minute == 8'h00) &&
      (out_alarm_hour == 8'h00))
    else $error("no-alarm result carries time bytes");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the RTC alarm time calculation unit.
`timescale 1ns / 100ps

module testbench
  import rtcalarm_pkg::*;
;

  // Expected contents of one result strobe.
  typedef struct packed {
    logic       valid;
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
  } alarm_bytes_t;

  // Works out the alarm bytes for every accepted request and checks the result
  // strobes against them in order. It keeps its own copy of the two mode bits.
  class alarm_time_checker;
    bit           bcd_mode = 1'b1;
    bit           h12_mode = 1'b0;
    int unsigned  error_count = 0;
    alarm_bytes_t expected_alarms[$];

    function int unsigned byte_value(input logic [7:0] b);
      if (bcd_mode) begin
        return int'(b[3:0]) + 10 * int'(b[7:4]);
      end
      return int'(b);
    endfunction

    function logic [7:0] time_byte(input int unsigned v);
      if (bcd_mode) begin
        return 8'(((v / 10) << 4) | (v % 10));
      end
      return 8'(v);
    endfunction

    function alarm_bytes_t compute_alarm(input logic [7:0] s, input logic [7:0] m,
                                         input logic [7:0] h, input logic [16:0] d);
      int unsigned  delay;
      int unsigned  hr;
      int unsigned  tod;
      int unsigned  ah;
      int unsigned  h12v;
      bit           pm;
      alarm_bytes_t r;
      r = '0;
      if (d == 0) begin
        return r;
      end
      delay = d;
      if (delay > MAX_DELAY) begin
        delay = MAX_DELAY;
      end
      if (h12_mode) begin
        pm = h[7];
        hr = byte_value(h & {1'b0, HOUR_MASK});
        if (pm && hr < NOON_HOUR) begin
          hr = hr + NOON_HOUR;
        end
        if (!pm && hr == NOON_HOUR) begin
          hr = 0;
        end
      end else begin
        hr = byte_value(h);
      end
      tod = hr * HOUR_SECONDS + byte_value(m) * 60 + byte_value(s);
      tod = (tod + delay) % DAY_SECONDS;
      ah = tod / HOUR_SECONDS;
      r.valid  = 1'b1;
      r.second = time_byte(tod % 60);
      r.minute = time_byte((tod % HOUR_SECONDS) / 60);
      if (h12_mode) begin
        pm = (ah >= NOON_HOUR);
        h12v = ah % NOON_HOUR;
        if (h12v == 0) begin
          h12v = NOON_HOUR;
        end
        r.hour = time_byte(h12v) | (pm ? PM_BIT : 8'h00);
      end else begin
        r.hour = time_byte(ah);
      end
      return r;
    endfunction

    function void note_config(input logic [1:0] index, input logic data);
      if (index == CFG_IDX_BCD) begin
        bcd_mode = data;
      end else if (index == CFG_IDX_H12) begin
        h12_mode = data;
      end
    endfunction

    function void note_request(input logic [7:0] s, input logic [7:0] m,
                               input logic [7:0] h, input logic [16:0] d);
      expected_alarms.push_back(compute_alarm(s, m, h, d));
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(input logic valid, input logic [7:0] second,
                               input logic [7:0] minute, input logic [7:0] hour);
      alarm_bytes_t want;
      if (expected_alarms.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %b %h %h %h",
                 $time, valid, hour, minute, second);
        error_count++;
        return;
      end
      want = expected_alarms.pop_front();
      compare_field("alarm_valid", 8'(want.valid), 8'(valid));
      compare_field("alarm_second", want.second, second);
      compare_field("alarm_minute", want.minute, minute);
      compare_field("alarm_hour", want.hour, hour);
    endfunction
  endclass

  // The run is far shorter than this; it only catches a hung pipeline.
  localparam int unsigned CYCLE_LIMIT  = 100000;
  // Extra wait once the last result is in; this leaves a little margin.
  localparam int unsigned RESULT_SLACK = 8;
  localparam int unsigned DRAIN_LIMIT  = 64;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 66;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic [7:0]  in_now_second    = '0;
  logic [7:0]  in_now_minute    = '0;
  logic [7:0]  in_now_hour      = '0;
  logic [16:0] in_delay_seconds = '0;
  logic        out_valid;
  logic        out_alarm_valid;
  logic [7:0]  out_alarm_second;
  logic [7:0]  out_alarm_minute;
  logic [7:0]  out_alarm_hour;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index        = CFG_IDX_BCD;
  logic        cfg_wdata        = 1'b0;

  int unsigned       cycle_count = 0;
  alarm_time_checker alarm_chk   = new();

  rtc_alarm_time_compute_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_now_second    (in_now_second),
    .in_now_minute    (in_now_minute),
    .in_now_hour      (in_now_hour),
    .in_delay_seconds (in_delay_seconds),
    .out_valid        (out_valid),
    .out_alarm_valid  (out_alarm_valid),
    .out_alarm_second (out_alarm_second),
    .out_alarm_minute (out_alarm_minute),
    .out_alarm_hour   (out_alarm_hour),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a run that has not finished by now has lost results somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, so the values seen are
  // those that were settled during the cycle that the edge closes. Result
  // checking comes before noting a new request; since every result is registered
  // through the pipeline ranks, the two can never concern the same request anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        alarm_chk.check_result(out_alarm_valid, out_alarm_second, out_alarm_minute,
                               out_alarm_hour);
      end
      if (start && !busy) begin
        alarm_chk.note_request(in_now_second, in_now_minute, in_now_hour,
                               in_delay_seconds);
      end
      if (cfg_valid && cfg_ready) begin
        alarm_chk.note_config(cfg_index, cfg_wdata);
      end
    end
  end

  // Presents one request and holds it until the block takes it. start is left
  // high on return, so that a following request can go out on the very next
  // cycle without start being lowered and raised in the same time step.
  task automatic send_request(input logic [7:0] s, input logic [7:0] m,
                              input logic [7:0] h, input logic [16:0] d);
    start            <= 1'b1;
    in_now_second    <= s;
    in_now_minute    <= m;
    in_now_hour      <= h;
    in_delay_seconds <= d;
    do @(posedge clk); while (busy);
  endtask

  // A zero gap leaves start alone, so back-to-back requests keep it high.
  task automatic pause(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Mostly no gap or a short one, now and then a long one; a steady phase
  // sends its requests back to back.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Waits until every outstanding request has produced its result, giving up
  // at DRAIN_LIMIT, then lets the pipeline run empty before the mode may change.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (alarm_chk.expected_alarms.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (RESULT_SLACK) @(posedge clk);
  endtask

  // Writes both mode registers, one per handshake, with valid held high across
  // the pair. Only called when the pipeline is empty.
  task automatic set_mode(input bit bcd, input bit h12);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_BCD;
    cfg_wdata <= bcd;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_IDX_H12;
    cfg_wdata <= h12;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Delays: a few zero, many short, many anywhere in the day, a cluster at the
  // saturation point, and the rest over the whole 17-bit range.
  function automatic logic [16:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return '0;
    end
    if (r < 35) begin
      return 17'($urandom_range(1, 120));
    end
    if (r < 60) begin
      return 17'($urandom_range(1, 86399));
    end
    if (r < 75) begin
      return 17'($urandom_range(86390, 86410));
    end
    return 17'($urandom_range(0, 131071));
  endfunction

  // Most requests carry a well-formed clock time in the current format; the
  // remainder are arbitrary bytes, which also exercises every input bit.
  task automatic random_request(input bit h12);
    logic [7:0] s;
    logic [7:0] m;
    logic [7:0] h;
    if ($urandom_range(0, 99) < 75) begin
      s = alarm_chk.time_byte($urandom_range(0, 59));
      m = alarm_chk.time_byte($urandom_range(0, 59));
      if (h12) begin
        h = alarm_chk.time_byte($urandom_range(1, 12));
        if ($urandom_range(0, 1) != 0) begin
          h = h | PM_BIT;
        end
      end else begin
        h = alarm_chk.time_byte($urandom_range(0, 23));
      end
    end else begin
      s = 8'($urandom());
      m = 8'($urandom());
      h = 8'($urandom());
    end
    send_request(s, m, h, pick_delay());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests in the reset mode, BCD and 24-hour: a zero delay,
    // wrap past midnight, saturation of the delay, and bytes that are not
    // valid BCD digits.
    send_request(8'h30, 8'h15, 8'h10, 17'd0);
    send_request(8'h59, 8'h59, 8'h23, 17'd1);
    pause(pick_gap(1'b0));
    send_request(8'h00, 8'h00, 8'h00, 17'd86399);
    send_request(8'h00, 8'h00, 8'h00, 17'd86400);
    send_request(8'hFF, 8'hFF, 8'hFF, 17'h1FFFF);
    pause(pick_gap(1'b0));
    send_request(8'h99, 8'h99, 8'h99, 17'd3661);
    send_request(8'h00, 8'h00, 8'h00, 17'd1);
    drain_results();

    // Binary 12-hour: midnight and noon on both sides, an hour of zero with
    // PM set, hours above twelve, and a fully set hour byte.
    set_mode(1'b0, 1'b1);
    send_request(8'd0, 8'd0, 8'h0C, 17'd1);
    send_request(8'd59, 8'd59, 8'h8B, 17'd1);
    send_request(8'd59, 8'd59, 8'h0B, 17'd1);
    send_request(8'd0, 8'd0, 8'h8C, 17'd60);
    pause(pick_gap(1'b0));
    send_request(8'd0, 8'd0, 8'h80, 17'd5);
    send_request(8'd0, 8'd0, 8'h0D, 17'd5);
    send_request(8'd0, 8'd0, 8'h8D, 17'd5);
    send_request(8'hFF, 8'hFF, 8'hFF, 17'h1FFFF);
    send_request(8'd0, 8'd0, 8'h01, 17'd0);
    drain_results();

    // BCD 12-hour: crossing into noon and into midnight, and a hour byte
    // with invalid BCD below the PM bit.
    set_mode(1'b1, 1'b1);
    send_request(8'h59, 8'h59, 8'h11, 17'd1);
    send_request(8'h00, 8'h00, 8'h12, 17'd30);
    send_request(8'h59, 8'h59, 8'h91, 17'd1);
    pause(pick_gap(1'b0));
    send_request(8'h00, 8'h00, 8'h7F, 17'd100);
    send_request(8'h00, 8'h00, 8'h00, 17'd1);
    drain_results();

    // Binary 24-hour extremes.
    set_mode(1'b0, 1'b0);
    send_request(8'd59, 8'd59, 8'd23, 17'd1);
    send_request(8'hFF, 8'hFF, 8'hFF, 17'd86399);
    send_request(8'd0, 8'd0, 8'd0, 17'd86400);
    send_request(8'd0, 8'd0, 8'd0, 17'd0);
    drain_results();

    // Random phases. The first four go through every combination of the two
    // mode bits; later ones pick the mode at random. About one phase in four
    // runs with no gaps at all.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      bit bcd_sel;
      bit h12_sel;
      bit steady;
      if (phase < 4) begin
        bcd_sel = !phase[0];
        h12_sel = phase[0] ^ phase[1];
      end else begin
        bcd_sel = $urandom_range(0, 1);
        h12_sel = $urandom_range(0, 1);
      end
      steady = ($urandom_range(0, 3) == 0);
      set_mode(bcd_sel, h12_sel);
      // The checker picks up the new mode from the write handshakes; wait for the next
      // edge so that its copy is current before bytes are encoded from it.
      @(posedge clk);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        random_request(h12_sel);
        pause(pick_gap(steady));
      end
      drain_results();
    end

    if (alarm_chk.expected_alarms.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, alarm_chk.expected_alarms.size());
      alarm_chk.error_count++;
    end
    if (alarm_chk.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: rtc_alarm_time_compute_unit.f
rtl/core/rtcalarm_pkg.sv
rtl/core/rtc_alarm_time_compute_unit.sv
tb/testbench.sv
